// ===== rtl/owrse_pkg.sv =====
`timescale 1ns / 1ps
package owrse_pkg;

	localparam int unsigned ROM_LEN = 64;
	localparam int unsigned POS_W = 7;
	localparam int unsigned IDX_W = 6;
	localparam int unsigned FAMILY_W = 8;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_PAIR  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_BIT         = 3'd0,
		ST_FOUND       = 3'd1,
		ST_ZERO_FAMILY = 3'd2,
		ST_ABORT       = 3'd3,
		ST_STARTED     = 3'd4,
		ST_NO_MORE     = 3'd5,
		ST_CLEARED     = 3'd6,
		ST_IGNORED     = 3'd7
	} status_t;

	localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(ROM_LEN);

	typedef struct packed {
		logic [ROM_LEN-1:0] rom_bits;
		logic [POS_W-1:0]   last_discrepancy;
		logic               last_device_seen;
		logic [POS_W-1:0]   pass_zero_mark;
		logic [POS_W-1:0]   bit_counter;
		logic               pass_active;
	} search_state_t;

	typedef struct packed {
		logic               presence;
		logic               id_bit;
		logic               comp_bit;
		op_t                op;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic               write_bit;
		logic [POS_W-1:0]   bit_index;
		logic [ROM_LEN-1:0] rom_code;
		logic               last_device;
	} result_t;

endpackage

// ===== rtl/owrse_decide.sv =====
`timescale 1ns / 1ps
module owrse_decide (
	input  owrse_pkg::search_state_t cur,
	input  owrse_pkg::item_t         item,
	output owrse_pkg::search_state_t nxt,
	output owrse_pkg::result_t       res
);
	import owrse_pkg::*;

	logic [POS_W-1:0] pos;
	logic [IDX_W-1:0] idx;
	logic             dir;
	logic [POS_W-1:0] zero_mark;
	logic [ROM_LEN-1:0] rom_new;

	assign pos = cur.bit_counter;
	assign idx = IDX_W'(pos - POS_FIRST);

	always_comb begin
		zero_mark = cur.pass_zero_mark;
		if (item.id_bit != item.comp_bit) begin
			dir = item.id_bit;
		end else begin
			if (pos < cur.last_discrepancy) begin
				dir = cur.rom_bits[idx];
			end else begin
				dir = (pos == cur.last_discrepancy);
			end
			if (!dir) begin
				zero_mark = pos;
			end
		end
		rom_new = cur.rom_bits;
		rom_new[idx] = dir;
	end

	always_comb begin
		nxt = cur;
		res = '0;
		res.status = ST_IGNORED;
		case (item.op)
			OP_START: begin
				if (cur.last_device_seen) begin
					res.status = ST_NO_MORE;
				end else if (!item.presence) begin
					nxt.last_discrepancy = '0;
					nxt.last_device_seen = 1'b0;
					nxt.pass_active = 1'b0;
					nxt.bit_counter = POS_FIRST;
					nxt.pass_zero_mark = '0;
					res.status = ST_CLEARED;
				end else begin
					nxt.pass_active = 1'b1;
					nxt.bit_counter = POS_FIRST;
					nxt.pass_zero_mark = '0;
					res.status = ST_STARTED;
				end
			end
			OP_CLEAR: begin
				nxt.last_discrepancy = '0;
				nxt.last_device_seen = 1'b0;
				nxt.pass_active = 1'b0;
				nxt.bit_counter = POS_FIRST;
				nxt.pass_zero_mark = '0;
				res.status = ST_CLEARED;
			end
			OP_PAIR: begin
				if (!cur.pass_active) begin
					res.status = ST_IGNORED;
				end else if (item.id_bit && item.comp_bit) begin
					// no device answered the slot
					nxt.last_discrepancy = '0;
					nxt.last_device_seen = 1'b0;
					nxt.pass_active = 1'b0;
					nxt.bit_counter = POS_FIRST;
					nxt.pass_zero_mark = '0;
					res.status = ST_ABORT;
				end else begin
					nxt.rom_bits = rom_new;
					nxt.pass_zero_mark = zero_mark;
					res.write_bit = dir;
					res.bit_index = pos;
					if (pos != POS_LAST) begin
						nxt.bit_counter = pos + POS_FIRST;
						res.status = ST_BIT;
					end else if (cur.rom_bits[FAMILY_W-1:0] == '0) begin
						// family byte zero: drop the whole search
						nxt.last_discrepancy = '0;
						nxt.last_device_seen = 1'b0;
						nxt.pass_active = 1'b0;
						nxt.bit_counter = POS_FIRST;
						nxt.pass_zero_mark = '0;
						res.status = ST_ZERO_FAMILY;
					end else begin
						nxt.pass_active = 1'b0;
						nxt.bit_counter = POS_FIRST;
						nxt.last_discrepancy = zero_mark;
						nxt.last_device_seen = (zero_mark == '0);
						res.status = ST_FOUND;
						res.rom_code = rom_new;
						res.last_device = (zero_mark == '0);
					end
				end
			end
			default: begin
				res.status = ST_IGNORED;
			end
		endcase
	end

endmodule

// ===== rtl/one_wire_rom_search_engine.sv =====
`timescale 1ns / 1ps
// 1-Wire Search ROM engine. Every input item (start with presence, id bit pair,
// or clear) yields exactly one result item. An item is decided in the cycle it
// is accepted and its result sits in the output register the next cycle, so
// the block takes one item per clock; the only limit is the output register,
// which accepts a new item whenever it is empty or being drained that cycle.
// For a bit pair the result carries the bit to write and its position 1..64;
// at bit 64 with a nonzero family byte it carries the found code and the last-device flag.
module one_wire_rom_search_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] presence, [1] id_bit, [2] comp_bit, zero pad
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // [0] write_bit, [7:1] bit_index, [71:8] rom_code,
	                                    // [72] last_device, zero pad
	output logic [2:0]  m_axis_tuser    // [2:0] status
);
	import owrse_pkg::*;

	search_state_t state_q;
	search_state_t state_next;
	item_t         item;
	result_t       res;
	result_t       res_q;
	logic          out_valid_q;
	logic          accept;

	assign item.presence   = s_axis_tdata[0];
	assign item.id_bit     = s_axis_tdata[1];
	assign item.comp_bit   = s_axis_tdata[2];
	assign item.op         = op_t'(s_axis_tuser);

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	owrse_decide u_decide (
		.cur  (state_q),
		.item (item),
		.nxt  (state_next),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bits <= '0;
			state_q.last_discrepancy <= '0;
			state_q.last_device_seen <= 1'b0;
			state_q.pass_zero_mark <= '0;
			state_q.bit_counter <= POS_FIRST;
			state_q.pass_active <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = res_q.status;
	assign m_axis_tdata  = {7'd0, res_q.last_device, res_q.rom_code, res_q.bit_index,
		res_q.write_bit};

endmodule

// ===== test/owrse_search_checker.sv =====
`timescale 1ns / 1ps
module owrse_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [0] presence, [1] id_bit, [2] comp_bit, zero pad
	input  logic [1:0]  s_axis_tuser,   // [1:0] op
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,   // [0] write_bit, [7:1] bit_index, [71:8] rom_code,
	                                    // [72] last_device, zero pad
	input  logic [2:0]  m_axis_tuser,   // [2:0] status
	output int          mismatches,
	output int          outstanding
);
	import owrse_pkg::*;

	// search state as seen by the bus master
	logic [ROM_LEN-1:0] rom_reg = '0;
	logic [POS_W-1:0]   resume_pos = '0;
	logic               bus_done = 1'b0;
	logic [POS_W-1:0]   zero_pick = '0;
	logic [POS_W-1:0]   slot_pos = POS_FIRST;
	logic               in_pass = 1'b0;

	result_t            expected_results[$];
	int                 bad = 0;

	function automatic void forget_search();
		resume_pos = '0;
		bus_done = 1'b0;
		in_pass = 1'b0;
		slot_pos = POS_FIRST;
		zero_pick = '0;
	endfunction

	function automatic result_t search_decide(op_t op, logic pres, logic idb, logic cmpb);
		result_t r;
		logic [IDX_W-1:0] sh;
		logic dir;
		r = '0;
		r.status = ST_IGNORED;
		case (op)
			OP_START: begin
				if (bus_done) begin
					r.status = ST_NO_MORE;
				end else if (!pres) begin
					forget_search();
					r.status = ST_CLEARED;
				end else begin
					in_pass = 1'b1;
					slot_pos = POS_FIRST;
					zero_pick = '0;
					r.status = ST_STARTED;
				end
			end
			OP_CLEAR: begin
				forget_search();
				r.status = ST_CLEARED;
			end
			OP_PAIR: begin
				if (!in_pass) begin
					r.status = ST_IGNORED;
				end else if (idb && cmpb) begin
					// nobody answered the slot
					forget_search();
					r.status = ST_ABORT;
				end else begin
					sh = IDX_W'(slot_pos - POS_FIRST);
					if (idb != cmpb) begin
						dir = idb;
					end else begin
						if (slot_pos < resume_pos)
							dir = rom_reg[sh];
						else
							dir = (slot_pos == resume_pos);
						if (!dir)
							zero_pick = slot_pos;
					end
					rom_reg[sh] = dir;
					r.write_bit = dir;
					r.bit_index = slot_pos;
					if (slot_pos < POS_LAST) begin
						slot_pos = slot_pos + POS_FIRST;
						r.status = ST_BIT;
					end else begin
						in_pass = 1'b0;
						slot_pos = POS_FIRST;
						resume_pos = zero_pick;
						if (resume_pos == '0)
							bus_done = 1'b1;
						if (rom_reg[FAMILY_W-1:0] == '0) begin
							forget_search();
							r.status = ST_ZERO_FAMILY;
						end else begin
							r.status = ST_FOUND;
							r.rom_code = rom_reg;
							r.last_device = bus_done;
						end
					end
				end
			end
			default: r.status = ST_IGNORED;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t seen;
		result_t want;
		if (!arst_n) begin
			rom_reg = '0;
			forget_search();
			expected_results.delete();
		end else begin
			// drain first: a result never leaves in the cycle its item enters
			if (m_axis_tvalid && m_axis_tready) begin
				seen.status = status_t'(m_axis_tuser);
				seen.write_bit = m_axis_tdata[0];
				seen.bit_index = m_axis_tdata[7:1];
				seen.rom_code = m_axis_tdata[71:8];
				seen.last_device = m_axis_tdata[72];
				if (expected_results.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("%0t: result item with none pending: status %0d idx %0d",
							$time, seen.status, seen.bit_index);
				end else begin
					want = expected_results.pop_front();
					if (seen.status !== want.status || seen.write_bit !== want.write_bit ||
						seen.bit_index !== want.bit_index || seen.rom_code !== want.rom_code ||
						seen.last_device !== want.last_device) begin
						bad++;
						if (bad <= 10) begin
							$display("%0t: expected status %0d wb %0b idx %0d code %h last %0b",
								$time, want.status, want.write_bit, want.bit_index,
								want.rom_code, want.last_device);
							$display("%0t:   actual status %0d wb %0b idx %0d code %h last %0b",
								$time, seen.status, seen.write_bit, seen.bit_index,
								seen.rom_code, seen.last_device);
						end
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(search_decide(op_t'(s_axis_tuser), s_axis_tdata[0],
					s_axis_tdata[1], s_axis_tdata[2]));
		end
		mismatches <= bad;
		outstanding <= expected_results.size();
	end

endmodule

// ===== test/one_wire_rom_search_engine_tb.sv =====
`timescale 1ns / 1ps
module one_wire_rom_search_engine_tb;
	import owrse_pkg::*;

	localparam int ITEM_GOAL = 1750;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	int mismatches;
	int outstanding;
	int items_sent = 0;
	int quiet_cycles = 0;
	int hold_tickets = 0;
	bit calm = 1'b0;
	int dens_choices[4] = '{0, 3, 15, 50};

	one_wire_rom_search_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	owrse_search_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic rand_bit();
		return 1'($urandom_range(1));
	endfunction

	task automatic send_item(op_t op, logic pres, logic idb, logic cmpb);
		while (!calm && $urandom_range(99) < 21) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, cmpb, idb, pres};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	// start a pass and walk all 64 slots; a cut either aborts or restarts the pass
	task automatic run_pass(int dens, bit zero_fam, int cut_at, bit restart);
		int k;
		logic a;
		k = 1;
		send_item(OP_START, 1'b1, rand_bit(), rand_bit());
		while (k <= ROM_LEN) begin
			if (k == cut_at) begin
				cut_at = 0;
				if (!restart) begin
					send_item(OP_PAIR, rand_bit(), 1'b1, 1'b1);
					return;
				end
				send_item(OP_START, 1'b1, rand_bit(), rand_bit());
				k = 1;
			end else begin
				if (zero_fam && k <= FAMILY_W) begin
					send_item(OP_PAIR, rand_bit(), 1'b0, 1'b1);
				end else if ($urandom_range(99) < dens) begin
					send_item(OP_PAIR, rand_bit(), 1'b0, 1'b0);
				end else begin
					a = rand_bit();
					send_item(OP_PAIR, rand_bit(), a, ~a);
				end
				k++;
			end
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// receiver: random stalls, calm stretches, and long hold-offs on request
	initial begin
		int hold_left;
		int served;
		hold_left = 0;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (served != hold_tickets) begin
				served = hold_tickets;
				hold_left = HOLD_CYCLES;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= calm || ($urandom_range(99) >= 21);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int round;
		int r;
		int dens;
		round = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner cases outside a full pass
		send_item(OP_PAIR, 1'b0, 1'b0, 1'b1);
		send_item(OP_NONE, 1'b0, 1'b0, 1'b0);
		send_item(OP_START, 1'b0, 1'b0, 1'b0);
		send_item(OP_CLEAR, 1'b0, 1'b0, 1'b0);
		send_item(OP_START, 1'b1, 1'b0, 1'b0);
		send_item(OP_PAIR, 1'b0, 1'b0, 1'b0);
		send_item(OP_PAIR, 1'b0, 1'b0, 1'b1);
		send_item(OP_PAIR, 1'b0, 1'b1, 1'b0);
		send_item(OP_PAIR, 1'b0, 1'b1, 1'b1);
		send_item(OP_PAIR, 1'b1, 1'b1, 1'b0);
		send_item(OP_START, 1'b1, 1'b1, 1'b1);
		send_item(OP_PAIR, 1'b1, 1'b1, 1'b0);
		send_item(OP_PAIR, 1'b1, 1'b0, 1'b0);
		send_item(OP_START, 1'b1, 1'b0, 1'b1);
		send_item(OP_PAIR, 1'b1, 1'b0, 1'b0);
		send_item(OP_CLEAR, 1'b1, 1'b1, 1'b1);
		send_item(OP_NONE, 1'b1, 1'b1, 1'b1);
		send_item(OP_START, 1'b0, 1'b1, 1'b1);

		// zero family, last device then no more, and a discrepancy walk
		run_pass(0, 1'b1, 0, 1'b0);
		run_pass(0, 1'b0, 0, 1'b0);
		send_item(OP_START, 1'b1, 1'b0, 1'b0);
		send_item(OP_CLEAR, 1'b0, 1'b0, 1'b0);
		run_pass(30, 1'b0, 0, 1'b0);
		run_pass(30, 1'b0, 0, 1'b0);
		run_pass(30, 1'b0, 0, 1'b0);

		while (items_sent < ITEM_GOAL) begin
			round++;
			if (round == 6)
				hold_tickets++;
			if (round == 14)
				wait_drained();
			calm = (round >= 20 && round < 28);
			r = $urandom_range(99);
			dens = dens_choices[$urandom_range(3)];
			if (r < 62) begin
				run_pass(dens, $urandom_range(99) < 8, 0, 1'b0);
				// after a pass with no discrepancy the bus is exhausted, unless the family byte was zero
				if (dens == 0) begin
					if ($urandom_range(1))
						send_item(OP_START, rand_bit(), rand_bit(), rand_bit());
					send_item(OP_CLEAR, rand_bit(), rand_bit(), rand_bit());
				end
			end else if (r < 72) begin
				run_pass(dens, 1'b0, $urandom_range(1, ROM_LEN), rand_bit());
			end else if (r < 80) begin
				send_item(OP_START, rand_bit(), rand_bit(), rand_bit());
			end else if (r < 86) begin
				send_item(OP_CLEAR, rand_bit(), rand_bit(), rand_bit());
			end else if (r < 93) begin
				send_item(OP_PAIR, rand_bit(), rand_bit(), rand_bit());
			end else begin
				send_item(OP_NONE, rand_bit(), rand_bit(), rand_bit());
			end
		end
		calm = 1'b0;

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/owrse_pkg.sv
rtl/owrse_decide.sv
rtl/one_wire_rom_search_engine.sv
test/owrse_search_checker.sv
test/one_wire_rom_search_engine_tb.sv
